@@ design/tlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared widths, defaults and transaction types of the address translator.
// ----------------------------------------------------------------------------
package tlb_pkg;

  localparam int VA_W            = 16;
  localparam int OFFSET_BITS     = 8;
  localparam int PAGE_W          = VA_W - OFFSET_BITS;
  localparam int PAGE_COUNT      = 1 << PAGE_W;
  localparam int FRAME_OUT_W     = 8;
  localparam int USE_W           = 16;
  localparam int HIT_W           = 32;
  localparam int DEF_TLB_ENTRIES = 16;
  localparam int DEF_FRAME_TOTAL = 256;

  localparam logic [USE_W-1:0] USE_MAX = '1;

  typedef struct packed {
    logic [PAGE_W-1:0]      page;
    logic [OFFSET_BITS-1:0] offset;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

@@ design/tlb_front.sv @@
// ----------------------------------------------------------------------------
// tlb_front
// Accepts addresses, splits them into page and offset, and queues them.
// ----------------------------------------------------------------------------
module tlb_front
  import tlb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [VA_W-1:0]   virtual_address,
  input  logic              pop,
  output queue_head_t       head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             take;

  assign busy = (count == CNT_W'(DEPTH));
  assign push = start && !busy;
  assign take = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].page   <= virtual_address[VA_W-1:OFFSET_BITS];
      slots[wr_ptr].offset <= virtual_address[OFFSET_BITS-1:0];
    end
  end

endmodule

@@ design/tlb_back.sv @@
// ----------------------------------------------------------------------------
// tlb_back
// TLB lookup, page table walk, frame allocation and LFU replacement.
// ----------------------------------------------------------------------------
module tlb_back
  import tlb_pkg::*;
#(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
  parameter int FRAME_TOTAL = DEF_FRAME_TOTAL
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  queue_head_t            head,
  output logic                   pop,
  output logic                   done,
  output logic [VA_W-1:0]        physical_address,
  output logic [FRAME_OUT_W-1:0] frame_number,
  output logic                   tlb_hit,
  output logic                   page_fault,
  output logic [HIT_W-1:0]       hit_total
);

  localparam int IDX_W   = $clog2(TLB_ENTRIES);
  localparam int FILL_W  = $clog2(TLB_ENTRIES + 1);
  localparam int FRAME_W = $clog2(FRAME_TOTAL);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;

  logic [PAGE_W-1:0]      cur_page;
  logic [OFFSET_BITS-1:0] cur_off;
  logic [FRAME_W-1:0]     pt_rdata;
  logic                   mapped_r;

  logic [FRAME_W-1:0]     page_frame [PAGE_COUNT];
  logic [PAGE_COUNT-1:0]  page_mapped;

  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [PAGE_W-1:0]      tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame [TLB_ENTRIES];
  logic [USE_W-1:0]       tlb_use   [TLB_ENTRIES];
  logic [FILL_W-1:0]      fill;
  logic [FRAME_W-1:0]     nff;
  logic [HIT_W-1:0]       hit_counter;

  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       best_idx;
  logic [USE_W-1:0]       best_cnt;
  logic [FRAME_W-1:0]     ins_frame;

  logic                   hit;
  logic [IDX_W-1:0]       hit_idx;
  logic [FRAME_W-1:0]     miss_frame;
  logic [FRAME_W-1:0]     look_frame;
  logic                   tlb_full;
  logic                   fault;
  logic                   scan_less;
  logic                   scan_last;
  logic [IDX_W-1:0]       victim;
  logic                   ins_en;
  logic [IDX_W-1:0]       ins_slot;
  logic [FRAME_W-1:0]     ins_frame_val;

  // lowest matching index wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (tlb_page[i] == cur_page)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign pop           = (state == S_IDLE) && head.valid;
  assign miss_frame    = mapped_r ? pt_rdata : nff;
  assign look_frame    = hit ? tlb_frame[hit_idx] : miss_frame;
  assign tlb_full      = (fill == FILL_W'(TLB_ENTRIES));
  assign fault         = (state == S_LOOK) && !hit && !mapped_r;
  assign scan_less     = (tlb_use[scan_idx] < best_cnt);
  assign scan_last     = (scan_idx == IDX_W'(TLB_ENTRIES - 1));
  assign victim        = scan_less ? scan_idx : best_idx;
  assign ins_en        = ((state == S_LOOK) && !hit && !tlb_full) ||
                         ((state == S_SCAN) && scan_last);
  assign ins_slot      = (state == S_SCAN) ? victim : fill[IDX_W-1:0];
  assign ins_frame_val = (state == S_SCAN) ? ins_frame : miss_frame;
  assign hit_total     = hit_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tlb_valid   <= '0;
      page_mapped <= '0;
      fill        <= '0;
      nff         <= '0;
      hit_counter <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == S_LOOK);
      if (ins_en) begin
        tlb_valid[ins_slot] <= 1'b1;
      end
      if (ins_en && (state == S_LOOK)) begin
        fill <= fill + 1'b1;
      end
      if (fault) begin
        page_mapped[cur_page] <= 1'b1;
        if (nff == FRAME_W'(FRAME_TOTAL - 1)) begin
          nff <= '0;
        end else begin
          nff <= nff + 1'b1;
        end
      end
      if ((state == S_LOOK) && hit) begin
        hit_counter <= hit_counter + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!hit && tlb_full) begin
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (fault) begin
      page_frame[cur_page] <= nff;
    end
    if (pop) begin
      pt_rdata <= page_frame[head.item.page];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_page <= head.item.page;
      cur_off  <= head.item.offset;
      mapped_r <= page_mapped[head.item.page];
    end

    if (ins_en) begin
      tlb_page[ins_slot]  <= cur_page;
      tlb_frame[ins_slot] <= ins_frame_val;
      tlb_use[ins_slot]   <= '0;
    end else if ((state == S_LOOK) && hit && (tlb_use[hit_idx] != USE_MAX)) begin
      tlb_use[hit_idx] <= tlb_use[hit_idx] + 1'b1;
    end

    // victim search: walk the entries, keep the first lowest count
    if (state == S_LOOK) begin
      best_idx  <= '0;
      best_cnt  <= tlb_use[0];
      scan_idx  <= IDX_W'(1);
      ins_frame <= miss_frame;
    end else if (state == S_SCAN) begin
      if (scan_less) begin
        best_idx <= scan_idx;
        best_cnt <= tlb_use[scan_idx];
      end
      scan_idx <= scan_idx + 1'b1;
    end

    if (state == S_LOOK) begin
      physical_address <= {PAGE_W'(look_frame), cur_off};
      frame_number     <= FRAME_OUT_W'(look_frame);
      tlb_hit          <= hit;
      page_fault       <= fault;
    end
  end

endmodule

@@ design/tlb_lfu_address_translator.sv @@
// An accepted address is queued, popped into the lookup registers, and the result
// and done are registered at the end of the lookup state. A new address is taken
// only from idle, after the last lookup and any walk end; a miss with a full
// TLB walks the use counts one entry per cycle. A 2-deep queue absorbs bursts.
// Results cannot be stalled; done is high for one cycle per transaction.
// Reset clears the TLB valid bits, page-mapped bits and counters.
// ----------------------------------------------------------------------------
// tlb_lfu_address_translator
// Virtual to physical translation through an LFU TLB backed by a page table.
// ----------------------------------------------------------------------------
module tlb_lfu_address_translator
  import tlb_pkg::*;
#(
  parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
  parameter int FRAME_TOTAL = DEF_FRAME_TOTAL
)
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [VA_W-1:0]        virtual_address,
  output logic                   done,
  output logic [VA_W-1:0]        physical_address,
  output logic [FRAME_OUT_W-1:0] frame_number,
  output logic                   tlb_hit,
  output logic                   page_fault,
  output logic [HIT_W-1:0]       hit_total
);

  queue_head_t head;
  logic        pop;

  tlb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .virtual_address (virtual_address),
    .pop             (pop),
    .head            (head)
  );

  tlb_back #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .FRAME_TOTAL (FRAME_TOTAL)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .done             (done),
    .physical_address (physical_address),
    .frame_number     (frame_number),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .hit_total        (hit_total)
  );

endmodule

@@ bench/tb_tlb_lfu_address_translator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tlb_lfu_address_translator
// Self-checking bench for the LFU TLB translator. A directed sequence covers the
// address extremes, frame zero, fill order, tie-broken replacement and
// eviction with the page table kept. It is followed by weighted random traffic
// over hot and warm page sets and the whole page range. A transaction-level
// predictor scores every done strobe.
// ----------------------------------------------------------------------------
module tb_tlb_lfu_address_translator;
  import tlb_pkg::*;

  localparam int TLB_N       = DEF_TLB_ENTRIES;
  localparam int FRAME_N     = DEF_FRAME_TOTAL;
  localparam int GAP_MAX     = 17;
  localparam int QUIET_LIMIT = 400;
  localparam int RANDOM_LOOKUPS = 1900;

  typedef struct packed {
    logic [VA_W-1:0]        phys;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   hit;
    logic                   fault;
    logic [HIT_W-1:0]       hits;
  } translation_t;

  typedef struct {
    logic [VA_W-1:0] va;
    int              gap;
  } lookup_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [VA_W-1:0]        virtual_address = '0;
  logic                   busy;
  logic                   done;
  logic [VA_W-1:0]        physical_address;
  logic [FRAME_OUT_W-1:0] frame_number;
  logic                   tlb_hit;
  logic                   page_fault;
  logic [HIT_W-1:0]       hit_total;

  tlb_lfu_address_translator #(
    .TLB_ENTRIES(TLB_N),
    .FRAME_TOTAL(FRAME_N)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .virtual_address (virtual_address),
    .done            (done),
    .physical_address(physical_address),
    .frame_number    (frame_number),
    .tlb_hit         (tlb_hit),
    .page_fault      (page_fault),
    .hit_total       (hit_total)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predicted translator state
  logic              tlb_live    [TLB_N]      = '{default: 1'b0};
  logic [PAGE_W-1:0] tlb_pages   [TLB_N]      = '{default: '0};
  int unsigned       tlb_frames  [TLB_N]      = '{default: 0};
  logic [USE_W-1:0]  tlb_uses    [TLB_N]      = '{default: '0};
  int                tlb_filled               = 0;
  logic              page_live   [PAGE_COUNT] = '{default: 1'b0};
  int unsigned       page_frames [PAGE_COUNT] = '{default: 0};
  int unsigned       free_frame               = 0;
  logic [HIT_W-1:0]  hits_seen                = '0;

  lookup_t      pending_lookups[$];
  translation_t expected_translations[$];
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;
  logic         took_item      = 1'b0;
  bit           burst_mode     = 1'b0;

  function automatic translation_t predict_translation(logic [VA_W-1:0] va);
    translation_t r;
    item_t        parts;
    int           slot;
    int unsigned  frame;
    logic [31:0]  wide;
    parts = va;
    r     = '0;
    slot  = -1;
    for (int i = 0; i < TLB_N; i++) begin
      if (slot < 0 && tlb_live[i] && tlb_pages[i] == parts.page) slot = i;
    end
    if (slot >= 0) begin
      frame = tlb_frames[slot];
      if (tlb_uses[slot] != USE_MAX) tlb_uses[slot] = tlb_uses[slot] + 1'b1;
      hits_seen = hits_seen + 1'b1;
      r.hit     = 1'b1;
    end else begin
      if (!page_live[parts.page]) begin
        page_frames[parts.page] = free_frame;
        page_live[parts.page]   = 1'b1;
        free_frame = (free_frame + 1 >= FRAME_N) ? 0 : free_frame + 1;
        r.fault    = 1'b1;
      end
      frame = page_frames[parts.page];
      if (tlb_filled < TLB_N) begin
        slot       = tlb_filled;
        tlb_filled = tlb_filled + 1;
      end else begin
        // lowest use count loses, lowest index on a tie
        slot = 0;
        for (int i = 1; i < TLB_N; i++) begin
          if (tlb_uses[i] < tlb_uses[slot]) slot = i;
        end
      end
      tlb_live[slot]   = 1'b1;
      tlb_pages[slot]  = parts.page;
      tlb_frames[slot] = frame;
      tlb_uses[slot]   = '0;
    end
    wide    = (frame << OFFSET_BITS) + parts.offset;
    r.phys  = wide[VA_W-1:0];
    r.frame = frame[FRAME_OUT_W-1:0];
    r.hits  = hits_seen;
    return r;
  endfunction

  task automatic check_field(string label, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t %s expected %0h actual %0h", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  task automatic queue_lookup(logic [PAGE_W-1:0] page, logic [OFFSET_BITS-1:0] offset);
    lookup_t l;
    l.va  = {page, offset};
    l.gap = burst_mode ? 0 : $urandom_range(0, GAP_MAX);
    pending_lookups.push_back(l);
  endtask

  task automatic wait_for_idle();
    while (pending_lookups.size() != 0 || start || expected_translations.size() != 0)
      @(posedge clk);
  endtask

  // Driver: change inputs on the falling edge only
  lookup_t next_lookup;
  int      gap_left  = 0;
  bit      gap_armed = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (!gap_armed && pending_lookups.size() != 0) begin
        gap_left  = pending_lookups[0].gap;
        gap_armed = 1'b1;
      end
      if (gap_armed && gap_left == 0) begin
        next_lookup = pending_lookups.pop_front();
        gap_armed   = 1'b0;
        virtual_address <= next_lookup.va;
        start           <= 1'b1;
      end else begin
        if (gap_armed) gap_left--;
        virtual_address <= VA_W'($urandom);
        start           <= 1'b0;
      end
    end
  end

  // Monitor: score results first, then predict the transaction taken this edge
  always @(posedge clk) begin
    translation_t want;
    took_item <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (expected_translations.size() == 0) begin
          $display("%0t unexpected result expected none actual pa %0h", $time,
                   physical_address);
          mismatch_count++;
        end else begin
          want = expected_translations.pop_front();
          check_field("physical_address", 64'(want.phys), 64'(physical_address));
          check_field("frame_number", 64'(want.frame), 64'(frame_number));
          check_field("tlb_hit", 64'(want.hit), 64'(tlb_hit));
          check_field("page_fault", 64'(want.fault), 64'(page_fault));
          check_field("hit_total", 64'(want.hits), 64'(hit_total));
        end
      end
      if (start && !busy) expected_translations.push_back(predict_translation(virtual_address));
      quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [PAGE_W-1:0]      hot  [6];
    logic [PAGE_W-1:0]      warm [30];
    logic [PAGE_W-1:0]      page;
    logic [OFFSET_BITS-1:0] offset;
    int                     pick;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Frame zero on page zero, offset extremes, top page
    queue_lookup('0, '0);
    queue_lookup('0, '1);
    queue_lookup('1, '1);
    queue_lookup('1, '0);
    // Fill the remaining slots in order
    for (int p = 1; p <= TLB_N - 2; p++) begin
      page   = PAGE_W'(p);
      offset = OFFSET_BITS'($urandom);
      queue_lookup(page, offset);
    end
    // Full TLB with all fresh entries at zero: tie goes to the lowest index
    queue_lookup(8'h80, 8'h3c);
    // Evicted page comes back without a fault
    queue_lookup(8'h01, 8'hc3);
    queue_lookup(8'haa, 8'haa);
    queue_lookup(8'h55, 8'h55);

    for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
      if (n % 50 == 0) burst_mode = ($urandom_range(0, 9) < 3);
      if (n % 500 == 0) begin
        foreach (hot[k]) hot[k] = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
        foreach (warm[k]) warm[k] = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) page = hot[$urandom_range(0, 5)];
      else if (pick < 90) page = warm[$urandom_range(0, 29)];
      else page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
      offset = OFFSET_BITS'($urandom);
      queue_lookup(page, offset);
    end

    wait_for_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ tlb_lfu_address_translator.f @@
design/tlb_pkg.sv
design/tlb_front.sv
design/tlb_back.sv
design/tlb_lfu_address_translator.sv
bench/tb_tlb_lfu_address_translator.sv
